>>> src/assert_macros.svh
// Assertion macros for the RTL files; ddp_back.sv is the one that uses them.
// Each use names a label and a property that is sampled on the rising edge of i_clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DDP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("%m: check failed");
`define DDP_ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) else $error("%m: check failed");
`else
`define DDP_ASSERT(lbl, prop)
`define DDP_ASSERT_NORST(lbl, prop)
`endif
`endif

>>> src/ddp_pkg.sv
`timescale 1ns / 1ps

package ddp_pkg;

    // Fixed point format of all intensities.
    localparam int FRAC_BITS = 12;
    // Working color width, error width, distance width.
    localparam int WW = FRAC_BITS + 10;
    localparam int EW = WW + 1;
    localparam int DW = 2 * EW + 2;
    // Scaled error magnitude width and reciprocal shift for the share division.
    localparam int AW = EW + 1;
    localparam int DK = AW + 4;
    localparam int RW = DK + 1;
    // Component to fixed point conversion: multiply by a reciprocal of 255.
    localparam int CK = 16;
    localparam int CRW = FRAC_BITS + 9;
    localparam logic [CRW-1:0] CONV_RECIP =
        CRW'(((longint'(1) << (FRAC_BITS + CK)) + 254) / 255);

    localparam logic [WW-1:0] HALF = WW'(longint'(1) << (FRAC_BITS - 1));
    localparam logic [3:0] MAX_TOTAL = 4'd12;

    // Register index of the mode register.
    localparam logic REG_HALFTONE = 1'b0;

    // Middle palette colors tried after the first guess.
    localparam logic [3:0] PAL_DARK_GREY  = 4'd8;
    localparam logic [3:0] PAL_PINK       = 4'd9;
    localparam logic [3:0] PAL_LT_GREEN   = 4'd10;
    localparam logic [3:0] PAL_OLIVE      = 4'd11;
    localparam logic [3:0] PAL_LAVENDER   = 4'd12;
    localparam logic [3:0] PAL_PURPLE     = 4'd13;
    localparam logic [3:0] PAL_BLUE_GREEN = 4'd14;
    localparam logic [3:0] PAL_LT_GREY    = 4'd15;

    typedef logic [5:0] t_cell;

    // One queued color: mode tag, raw components and fixed point components.
    typedef struct packed {
        logic            mode;
        logic [2:0][7:0] raw;
        logic [2:0][WW-1:0] fix;
    } t_item;

    // Class of each cell, indexed by y*8+x.
    localparam logic [5:0] CLASS_TBL [64] = '{
        6'd21, 6'd22, 6'd25, 6'd26, 6'd37, 6'd38, 6'd41, 6'd42,
        6'd20, 6'd23, 6'd24, 6'd27, 6'd36, 6'd39, 6'd40, 6'd43,
        6'd19, 6'd18, 6'd29, 6'd28, 6'd35, 6'd34, 6'd45, 6'd44,
        6'd16, 6'd17, 6'd30, 6'd31, 6'd32, 6'd33, 6'd46, 6'd47,
        6'd15, 6'd12, 6'd11, 6'd10, 6'd53, 6'd52, 6'd51, 6'd48,
        6'd14, 6'd13, 6'd8,  6'd9,  6'd54, 6'd55, 6'd50, 6'd49,
        6'd1,  6'd2,  6'd7,  6'd6,  6'd57, 6'd56, 6'd61, 6'd62,
        6'd0,  6'd3,  6'd4,  6'd5,  6'd58, 6'd59, 6'd60, 6'd63
    };

    // Cell (y*8+x) of each class.
    localparam t_cell CELL_OF_CLASS [64] = '{
        6'd56, 6'd48, 6'd49, 6'd57, 6'd58, 6'd59, 6'd51, 6'd50,
        6'd42, 6'd43, 6'd35, 6'd34, 6'd33, 6'd41, 6'd40, 6'd32,
        6'd24, 6'd25, 6'd17, 6'd16, 6'd8,  6'd0,  6'd1,  6'd9,
        6'd10, 6'd2,  6'd3,  6'd11, 6'd19, 6'd18, 6'd26, 6'd27,
        6'd28, 6'd29, 6'd21, 6'd20, 6'd12, 6'd4,  6'd5,  6'd13,
        6'd14, 6'd6,  6'd7,  6'd15, 6'd23, 6'd22, 6'd30, 6'd31,
        6'd39, 6'd47, 6'd46, 6'd38, 6'd37, 6'd36, 6'd44, 6'd45,
        6'd53, 6'd52, 6'd60, 6'd61, 6'd62, 6'd54, 6'd55, 6'd63
    };

    // Palette numerators over 15, packed {blue, green, red}.
    localparam logic [11:0] PAL15 [16] = '{
        12'h000, 12'h00F, 12'h0F0, 12'h0FF, 12'hF00, 12'hF0F, 12'hFF0, 12'hFFF,
        12'h555, 12'h77C, 12'h7C7, 12'h388, 12'hC77, 12'h838, 12'h883, 12'hAAA
    };

    // Fixed point value of each numerator over 15.
    localparam logic [WW-1:0] PAL_FIX [16] = '{
        WW'((0 << FRAC_BITS) / 15),  WW'((1 << FRAC_BITS) / 15),
        WW'((2 << FRAC_BITS) / 15),  WW'((3 << FRAC_BITS) / 15),
        WW'((4 << FRAC_BITS) / 15),  WW'((5 << FRAC_BITS) / 15),
        WW'((6 << FRAC_BITS) / 15),  WW'((7 << FRAC_BITS) / 15),
        WW'((8 << FRAC_BITS) / 15),  WW'((9 << FRAC_BITS) / 15),
        WW'((10 << FRAC_BITS) / 15), WW'((11 << FRAC_BITS) / 15),
        WW'((12 << FRAC_BITS) / 15), WW'((13 << FRAC_BITS) / 15),
        WW'((14 << FRAC_BITS) / 15), WW'((15 << FRAC_BITS) / 15)
    };

    // Rounded-up reciprocals of the weight totals; unused totals read zero.
    localparam logic [RW-1:0] RECIP [16] = '{
        RW'(0),
        RW'((longint'(1) << DK) / 1),
        RW'(((longint'(1) << DK) + 1) / 2),
        RW'(((longint'(1) << DK) + 2) / 3),
        RW'(((longint'(1) << DK) + 3) / 4),
        RW'(((longint'(1) << DK) + 4) / 5),
        RW'(((longint'(1) << DK) + 5) / 6),
        RW'(((longint'(1) << DK) + 6) / 7),
        RW'(((longint'(1) << DK) + 7) / 8),
        RW'(((longint'(1) << DK) + 8) / 9),
        RW'(((longint'(1) << DK) + 9) / 10),
        RW'(((longint'(1) << DK) + 10) / 11),
        RW'(((longint'(1) << DK) + 11) / 12),
        RW'(0), RW'(0), RW'(0)
    };

    // 4x4 Bayer matrix, indexed by y*4+x.
    localparam logic [3:0] BAYER4 [16] = '{
        4'd0, 4'd12, 4'd3, 4'd15, 4'd8, 4'd4, 4'd11, 4'd7,
        4'd2, 4'd14, 4'd1, 4'd13, 4'd10, 4'd6, 4'd9, 4'd5
    };

    // Fixed point component c of palette entry k.
    function automatic logic [WW-1:0] pal(input logic [3:0] k, input logic [1:0] c);
        logic [11:0] e;
        logic [3:0]  n;
        e = PAL15[k];
        unique case (c)
            2'd0:    n = e[3:0];
            2'd1:    n = e[7:4];
            default: n = e[11:8];
        endcase
        return PAL_FIX[n];
    endfunction

endpackage

>>> src/ddp_if.sv
`timescale 1ns / 1ps

// Color request channel.
interface ddp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// Pattern row channel.
interface ddp_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  row;
    logic [15:0] plane0_word;
    logic [15:0] plane1_word;
    logic [15:0] plane2_word;
    logic [15:0] plane3_word;
    logic        last_row;

    modport source (output valid, output row, output plane0_word, output plane1_word,
                    output plane2_word, output plane3_word, output last_row, input ready);
    modport sink   (input valid, input row, input plane0_word, input plane1_word,
                    input plane2_word, input plane3_word, input last_row, output ready);
endinterface

>>> src/dot_diffusion_pattern_generator.sv
`timescale 1ns / 1ps

// Ordered mode: a taken color moves the sequencer to ST_OUT, which loads the rows into the output
// register, one row per cycle while the receiver does not stall.
// Dot diffusion: a cell with unvisited neighbours takes longer than a cell without; the time per
// color is set by the one shared distance multiplier and the memory port.
// Up to three more colors wait in the input stage and the queue; rows leave through a register.
// Reset (synchronous, active low) clears the control state and sets the mode to dot diffusion.
module dot_diffusion_pattern_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ddp_in_if.sink      i_item,
    ddp_out_if.source   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic           r_mode;
    logic           q_push;
    logic           q_full;
    logic           q_valid;
    logic           q_pop;
    ddp_pkg::t_item front_data;
    ddp_pkg::t_item q_data;

    // Register port: the write lands in the access phase.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == ddp_pkg::REG_HALFTONE) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (psel && penable && pwrite && paddr[2] == ddp_pkg::REG_HALFTONE) begin
            r_mode <= pwdata[0];
        end
    end

    ddp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_mode   (r_mode),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_data (front_data)
    );

    ddp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_data),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (q_data),
        .i_pop   (q_pop)
    );

    ddp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_result  (o_result)
    );

endmodule

>>> src/ddp_queue.sv
`timescale 1ns / 1ps

module ddp_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ddp_pkg::t_item i_data,
    output logic           o_full,
    output logic           o_valid,
    output ddp_pkg::t_item o_data,
    input  logic           i_pop
);

    ddp_pkg::t_item r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> src/ddp_front.sv
`timescale 1ns / 1ps

module ddp_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_mode,
    ddp_in_if.sink         i_item,
    input  logic           i_q_full,
    output logic           o_q_push,
    output ddp_pkg::t_item o_q_data
);

    localparam int PW = ddp_pkg::CK + ddp_pkg::WW;

    logic            r_stg_vld;
    logic            r_mode;
    logic [2:0][7:0] r_raw;
    logic [PW-1:0]   prod [3];

    // The stage drains into the queue whenever the queue has room.
    assign o_q_push     = r_stg_vld && !i_q_full;
    assign i_item.ready = !r_stg_vld || !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_vld <= 1'b0;
        end else if (i_item.ready) begin
            r_stg_vld <= i_item.valid;
        end
    end

    // Capture the color and tag it with the mode in force.
    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_raw  <= {i_item.blue, i_item.green, i_item.red};
            r_mode <= i_mode;
        end
    end

    // Convert each component to fixed point: floor(c * 2^F / 255).
    always_comb begin
        o_q_data.mode = r_mode;
        o_q_data.raw  = r_raw;
        for (int c = 0; c < 3; c++) begin
            prod[c] = PW'(r_raw[c]) * PW'(ddp_pkg::CONV_RECIP);
            o_q_data.fix[c] = prod[c][ddp_pkg::CK +: ddp_pkg::WW];
        end
    end

endmodule

>>> src/ddp_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ddp_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  ddp_pkg::t_item i_q_data,
    output logic           o_q_pop,
    ddp_out_if.source      o_result
);

    localparam int WW = ddp_pkg::WW;
    localparam int EW = ddp_pkg::EW;
    localparam int DW = ddp_pkg::DW;
    localparam int AW = ddp_pkg::AW;
    localparam int PW = ddp_pkg::AW + ddp_pkg::RW;

    localparam int NB_DX [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
    localparam int NB_DY [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_LD, ST_DSQ, ST_DACC, ST_ERR,
        ST_DMUL, ST_DFIN, ST_NRD, ST_NWR, ST_OUT
    } t_state;

    t_state               r_state;
    ddp_pkg::t_item       r_item;
    logic [63:0]          r_vld;
    logic [5:0]           r_cls;
    ddp_pkg::t_cell       r_pos;
    logic [WW-1:0]        r_col [3];
    logic [3:0]           r_cand [5];
    logic [2:0]           r_m;
    logic [1:0]           r_c;
    logic [DW-1:0]        r_sq;
    logic [DW-1:0]        r_acc;
    logic [3:0]           r_best;
    logic [DW-1:0]        r_bestd;
    logic signed [EW-1:0] r_err [3];
    logic [7:0]           r_nmask;
    logic [3:0]           r_total;
    logic [1:0]           r_dc;
    logic                 r_dw;
    logic [PW-1:0]        r_prod;
    logic signed [AW-1:0] r_q [2][3];
    logic [2:0]           r_n;
    ddp_pkg::t_cell       r_naddr;
    logic [7:0]           r_plane [4][8];
    logic [3:0]           r_row;
    logic                 r_ov;
    logic [3:0]           r_out_row;
    logic [15:0]          r_out_word [4];
    logic                 r_out_last;

    // Working color memory: one write and one registered read per cycle.
    logic [3*WW-1:0]      mem [64];
    logic [3*WW-1:0]      r_mem_q;
    logic                 r_rdv;
    ddp_pkg::t_cell       rd_addr;
    logic                 mem_we;
    logic [3*WW-1:0]      wdata;

    logic [WW-1:0]        col_in [3];
    logic                 rh, gh, bh;
    logic signed [EW-1:0] diff;
    logic signed [2*EW-1:0] sq;
    logic [DW-1:0]        sum;
    logic [7:0]           nb_ok;
    logic [7:0]           nb_w2;
    ddp_pkg::t_cell       nb_addr [8];
    logic [3:0]           total;
    logic [AW-1:0]        amag;
    logic [AW-1:0]        qmag;
    logic signed [AW-1:0] wsum [3];
    logic                 load;
    logic [15:0]          word [4];
    logic [7:0]           thr;

    assign o_q_pop = (r_state == ST_IDLE) && i_q_valid;
    assign load    = !r_ov || o_result.ready;

    // Read address follows the step being set up.
    always_comb begin
        unique case (r_state)
            ST_RD:   rd_addr = ddp_pkg::CELL_OF_CLASS[r_cls];
            ST_NRD:  rd_addr = nb_addr[r_n];
            default: rd_addr = r_pos;
        endcase
    end

    // A cell never written for this color still holds the input color.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            col_in[c] = r_rdv ? r_mem_q[c*WW +: WW] : r_item.fix[c];
        end
        rh = $signed(col_in[0]) > $signed(ddp_pkg::HALF);
        gh = $signed(col_in[1]) > $signed(ddp_pkg::HALF);
        bh = $signed(col_in[2]) > $signed(ddp_pkg::HALF);
    end

    // Distance term of the current candidate and component.
    always_comb begin
        diff = $signed({r_col[r_c][WW-1], r_col[r_c]})
             - $signed({1'b0, ddp_pkg::pal(r_cand[r_m], r_c)});
        sq   = diff * diff;
        sum  = r_acc + r_sq;
    end

    // Unvisited neighbours of the current cell and their weights.
    always_comb begin
        int nx;
        int ny;
        total = 4'd0;
        for (int n = 0; n < 8; n++) begin
            nx = int'(r_pos[2:0]) + NB_DX[n];
            ny = int'(r_pos[5:3]) + NB_DY[n];
            nb_addr[n] = {ny[2:0], nx[2:0]};
            nb_w2[n]   = (NB_DX[n] == 0) || (NB_DY[n] == 0);
            nb_ok[n]   = (nx >= 0) && (nx <= 7) && (ny >= 0) && (ny <= 7)
                       && (ddp_pkg::CLASS_TBL[nb_addr[n]] > r_cls);
            if (nb_ok[n]) begin
                total = total + (nb_w2[n] ? 4'd2 : 4'd1);
            end
        end
    end

    // Share division by reciprocal multiply, and the neighbour update.
    always_comb begin
        amag = r_err[r_dc][EW-1] ? AW'(-r_err[r_dc]) : AW'(r_err[r_dc]);
        amag = r_dw ? (amag << 1) : amag;
        qmag = r_prod[ddp_pkg::DK +: AW];
        for (int c = 0; c < 3; c++) begin
            wsum[c] = $signed({{(AW-WW){col_in[c][WW-1]}}, col_in[c]})
                    + r_q[nb_w2[r_n]][c];
            wdata[c*WW +: WW] = wsum[c][WW-1:0];
        end
        mem_we = (r_state == ST_NWR);
    end

    // Row words for the row being loaded.
    always_comb begin
        thr = 8'd0;
        for (int p = 0; p < 4; p++) begin
            word[p] = 16'd0;
        end
        if (r_item.mode) begin
            for (int x = 0; x < 16; x++) begin
                thr = {ddp_pkg::BAYER4[{r_row[1:0], 2'(x)}],
                       ddp_pkg::BAYER4[{r_row[3:2], 2'(x >> 2)}]};
                for (int p = 0; p < 3; p++) begin
                    word[p][x] = thr < r_item.raw[p];
                end
            end
        end else begin
            for (int p = 0; p < 4; p++) begin
                word[p] = {r_plane[p][r_row[2:0]], r_plane[p][r_row[2:0]]};
            end
        end
    end

    // Sequencer over the 64 cells and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_vld   <= '0;
        end else begin
            if (o_result.ready && !(r_state == ST_OUT && load)) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_q_valid) begin
                        r_item <= i_q_data;
                        r_row  <= 4'd0;
                        r_cls  <= 6'd0;
                        r_vld  <= '0;
                        r_state <= i_q_data.mode ? ST_OUT : ST_RD;
                    end
                end
                ST_RD: begin
                    r_pos   <= ddp_pkg::CELL_OF_CLASS[r_cls];
                    r_state <= ST_LD;
                end
                ST_LD: begin
                    for (int c = 0; c < 3; c++) begin
                        r_col[c] <= col_in[c];
                    end
                    r_cand[0] <= {1'b0, bh, gh, rh};
                    r_cand[1] <= rh ? ddp_pkg::PAL_PINK : ddp_pkg::PAL_BLUE_GREEN;
                    r_cand[2] <= gh ? ddp_pkg::PAL_LT_GREEN : ddp_pkg::PAL_PURPLE;
                    r_cand[3] <= bh ? ddp_pkg::PAL_LAVENDER : ddp_pkg::PAL_OLIVE;
                    r_cand[4] <= ((rh && gh) || (rh && bh) || (gh && bh))
                               ? ddp_pkg::PAL_LT_GREY : ddp_pkg::PAL_DARK_GREY;
                    r_m     <= 3'd0;
                    r_c     <= 2'd0;
                    r_acc   <= '0;
                    r_state <= ST_DSQ;
                end
                ST_DSQ: begin
                    r_sq    <= DW'($unsigned(sq));
                    r_state <= ST_DACC;
                end
                ST_DACC: begin
                    if (r_c == 2'd2) begin
                        if (r_m == 3'd0 || r_bestd > sum) begin
                            r_bestd <= sum;
                            r_best  <= r_cand[r_m];
                        end
                        r_acc <= '0;
                        r_c   <= 2'd0;
                        if (r_m == 3'd4) begin
                            r_state <= ST_ERR;
                        end else begin
                            r_m     <= r_m + 3'd1;
                            r_state <= ST_DSQ;
                        end
                    end else begin
                        r_acc   <= sum;
                        r_c     <= r_c + 2'd1;
                        r_state <= ST_DSQ;
                    end
                end
                ST_ERR: begin
                    for (int c = 0; c < 3; c++) begin
                        r_err[c] <= $signed({r_col[c][WW-1], r_col[c]})
                                  - $signed({1'b0, ddp_pkg::pal(r_best, 2'(c))});
                    end
                    for (int p = 0; p < 4; p++) begin
                        r_plane[p][r_pos[5:3]][r_pos[2:0]] <= r_best[p];
                    end
                    r_nmask <= nb_ok;
                    r_total <= total;
                    r_dc    <= 2'd0;
                    r_dw    <= 1'b0;
                    if (total == 4'd0) begin
                        if (r_cls == 6'd63) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_cls   <= r_cls + 6'd1;
                            r_state <= ST_RD;
                        end
                    end else begin
                        r_state <= ST_DMUL;
                    end
                end
                ST_DMUL: begin
                    r_prod  <= PW'(amag) * PW'(ddp_pkg::RECIP[r_total]);
                    r_state <= ST_DFIN;
                end
                ST_DFIN: begin
                    r_q[r_dw][r_dc] <= r_err[r_dc][EW-1] ? -$signed(qmag) : $signed(qmag);
                    if (r_dc == 2'd2) begin
                        r_dc <= 2'd0;
                        if (r_dw) begin
                            r_n     <= 3'd0;
                            r_state <= ST_NRD;
                        end else begin
                            r_dw    <= 1'b1;
                            r_state <= ST_DMUL;
                        end
                    end else begin
                        r_dc    <= r_dc + 2'd1;
                        r_state <= ST_DMUL;
                    end
                end
                ST_NRD: begin
                    if (r_nmask[r_n]) begin
                        r_naddr <= nb_addr[r_n];
                        r_state <= ST_NWR;
                    end else if (r_n == 3'd7) begin
                        if (r_cls == 6'd63) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_cls   <= r_cls + 6'd1;
                            r_state <= ST_RD;
                        end
                    end else begin
                        r_n <= r_n + 3'd1;
                    end
                end
                ST_NWR: begin
                    r_vld[r_naddr] <= 1'b1;
                    if (r_n == 3'd7) begin
                        if (r_cls == 6'd63) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_cls   <= r_cls + 6'd1;
                            r_state <= ST_RD;
                        end
                    end else begin
                        r_n     <= r_n + 3'd1;
                        r_state <= ST_NRD;
                    end
                end
                ST_OUT: begin
                    if (load) begin
                        r_ov       <= 1'b1;
                        r_out_row  <= r_row;
                        r_out_last <= (r_row == 4'd15);
                        for (int p = 0; p < 4; p++) begin
                            r_out_word[p] <= word[p];
                        end
                        r_row <= r_row + 4'd1;
                        if (r_row == 4'd15) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Working color memory.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_naddr] <= wdata;
        end
        r_mem_q <= mem[rd_addr];
        r_rdv   <= r_vld[rd_addr];
    end

    assign o_result.valid       = r_ov;
    assign o_result.row         = r_out_row;
    assign o_result.plane0_word = r_out_word[0];
    assign o_result.plane1_word = r_out_word[1];
    assign o_result.plane2_word = r_out_word[2];
    assign o_result.plane3_word = r_out_word[3];
    assign o_result.last_row    = r_out_last;

    `DDP_ASSERT(a_total_range, (r_state == ST_DMUL) |-> (r_total != 4'd0 && r_total <= ddp_pkg::MAX_TOTAL))
    `DDP_ASSERT(a_nb_unvisited, (r_state == ST_NWR) |-> (ddp_pkg::CLASS_TBL[r_naddr] > r_cls))
    `DDP_ASSERT(a_out_done, (r_state == ST_OUT && load && r_row == 4'd15) |=> (r_state == ST_IDLE))
    `DDP_ASSERT_NORST(a_reset_quiet, $past(!i_rst_n) |-> !r_ov)

endmodule
